[design/deq_pkg.sv]
// Shared constants, types and ring-index helper for the double-ended queue.
`default_nettype none

package deq_pkg;

    // Geometry
    localparam int DEPTH  = 64;
    localparam int DATA_W = 32;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Request codes
    localparam logic [2:0] REQ_PUSH_BACK  = 3'd0;
    localparam logic [2:0] REQ_PUSH_FRONT = 3'd1;
    localparam logic [2:0] REQ_POP_BACK   = 3'd2;
    localparam logic [2:0] REQ_POP_FRONT  = 3'd3;
    localparam logic [2:0] REQ_DUMP_FWD   = 3'd4;
    localparam logic [2:0] REQ_DUMP_REV   = 3'd5;

    // Result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    // Datapath operations issued by the controller
    typedef enum logic [2:0] {
        OP_NONE,
        OP_PUSH_BACK,
        OP_PUSH_FRONT,
        OP_POP_BACK,
        OP_POP_FRONT,
        OP_ERROR,
        OP_DUMP_READ
    } cmd_op_t;

    // Controller to datapath
    typedef struct packed {
        cmd_op_t          op;
        logic [1:0]       err_status;
        logic             reverse;
        logic [IDX_W-1:0] walk;
        logic             last;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             empty;
        logic             full;
    } dp_stat_t;

    // (base + off) mod DEPTH, with base < DEPTH and off <= DEPTH
    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
        if (sum >= (CNT_W + 1)'(DEPTH))
            sum = sum - (CNT_W + 1)'(DEPTH);
        return IDX_W'(sum);
    endfunction

endpackage

`default_nettype wire

[design/deq_datapath.sv]
// Datapath: ring store, head and count registers, read stage and result registers.
`default_nettype none

module deq_datapath (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire deq_pkg::dp_cmd_t                cmd,
    input  wire logic signed [deq_pkg::DATA_W-1:0] push_value,
    output deq_pkg::dp_stat_t                    stat,
    output logic                                 result_valid,
    output logic signed [deq_pkg::DATA_W-1:0]    out_value,
    output logic [1:0]                           status,
    output logic                                 queue_empty,
    output logic                                 last_of_run
);
    import deq_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];

    logic [IDX_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [DATA_W-1:0] rd_data_reg;
    logic              rd_vld_reg;
    logic              rd_last_reg;
    logic              strobe_reg;
    logic [DATA_W-1:0] res_value_reg;
    logic [1:0]        res_status_reg;
    logic              res_empty_reg;
    logic              res_last_reg;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              imm_vld;
    logic [1:0]        imm_status;
    logic [CNT_W-1:0]  dump_off;

    // Status to the controller
    assign stat.count = count_reg;
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CNT_W'(DEPTH));

    // Ring offset of the entry a dump step reads
    assign dump_off = cmd.reverse ? CNT_W'(count_reg - CNT_W'(1) - CNT_W'(cmd.walk))
                                  : CNT_W'(cmd.walk);

    // Command decode
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        wr_addr    = head_reg;
        rd_en      = 1'b0;
        rd_addr    = head_reg;
        imm_vld    = 1'b0;
        imm_status = STAT_OK;
        case (cmd.op)
            OP_PUSH_BACK:
            begin
                wr_en      = 1'b1;
                wr_addr    = ring_add(head_reg, count_reg);
                count_next = count_reg + CNT_W'(1);
                imm_vld    = 1'b1;
            end
            OP_PUSH_FRONT:
            begin
                wr_en      = 1'b1;
                wr_addr    = ring_add(head_reg, CNT_W'(DEPTH - 1));
                head_next  = wr_addr;
                count_next = count_reg + CNT_W'(1);
                imm_vld    = 1'b1;
            end
            OP_POP_BACK:
            begin
                rd_en      = 1'b1;
                rd_addr    = ring_add(head_reg, count_reg - CNT_W'(1));
                count_next = count_reg - CNT_W'(1);
            end
            OP_POP_FRONT:
            begin
                rd_en      = 1'b1;
                rd_addr    = head_reg;
                head_next  = ring_add(head_reg, CNT_W'(1));
                count_next = count_reg - CNT_W'(1);
            end
            OP_ERROR:
            begin
                imm_vld    = 1'b1;
                imm_status = cmd.err_status;
            end
            OP_DUMP_READ:
            begin
                rd_en   = 1'b1;
                rd_addr = ring_add(head_reg, dump_off);
            end
            default:
            begin
            end
        endcase
    end

    // Ring store, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= DATA_W'(push_value);
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            count_reg   <= '0;
            rd_vld_reg  <= 1'b0;
            rd_last_reg <= 1'b0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            head_reg    <= head_next;
            count_reg   <= count_next;
            rd_vld_reg  <= rd_en;
            rd_last_reg <= rd_en &
                           ((cmd.op != OP_DUMP_READ) | cmd.last);
            strobe_reg  <= imm_vld | rd_vld_reg;
        end
    end

    // Result registers
    always_ff @(posedge clk)
    begin
        if (rd_vld_reg)
        begin
            res_value_reg  <= rd_data_reg;
            res_status_reg <= STAT_OK;
            res_empty_reg  <= (count_reg == '0);
            res_last_reg   <= rd_last_reg;
        end
        else if (imm_vld)
        begin
            res_value_reg  <= '0;
            res_status_reg <= imm_status;
            res_empty_reg  <= (count_next == '0);
            res_last_reg   <= 1'b1;
        end
    end

    assign result_valid = strobe_reg;
    assign out_value    = res_value_reg;
    assign status       = res_status_reg;
    assign queue_empty  = res_empty_reg;
    assign last_of_run  = res_last_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    a_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
        !(imm_vld && rd_vld_reg))
        else $error("immediate result collides with read result");

    a_read_to_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |=> strobe_reg)
        else $error("read data not presented as a result");

endmodule

`default_nettype wire

[design/deq_ctrl.sv]
// Controller: request decode and dump walk sequencing.
`default_nettype none

module deq_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [2:0]        req_type,
    input  wire deq_pkg::dp_stat_t stat,
    output logic                   busy,
    output deq_pkg::dp_cmd_t       cmd
);
    import deq_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DUMP = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] walk_reg, walk_next;
    logic             rev_reg, rev_next;
    logic             walk_last;

    assign busy = (state_reg != ST_IDLE);

    // Last dump step when the walk reaches count - 1
    assign walk_last = ((CNT_W'(walk_reg) + CNT_W'(1)) == stat.count);

    // Next state and command
    always_comb
    begin
        state_next     = state_reg;
        walk_next      = walk_reg;
        rev_next       = rev_reg;
        cmd.op         = OP_NONE;
        cmd.err_status = STAT_OK;
        cmd.reverse    = rev_reg;
        cmd.walk       = walk_reg;
        cmd.last       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (req_type)
                        REQ_PUSH_BACK, REQ_PUSH_FRONT:
                        begin
                            if (stat.full)
                            begin
                                cmd.op         = OP_ERROR;
                                cmd.err_status = STAT_FULL;
                            end
                            else
                                cmd.op = (req_type == REQ_PUSH_BACK) ? OP_PUSH_BACK
                                                                     : OP_PUSH_FRONT;
                        end
                        REQ_POP_BACK, REQ_POP_FRONT:
                        begin
                            if (stat.empty)
                            begin
                                cmd.op         = OP_ERROR;
                                cmd.err_status = STAT_EMPTY;
                            end
                            else
                            begin
                                cmd.op = (req_type == REQ_POP_BACK) ? OP_POP_BACK
                                                                    : OP_POP_FRONT;
                                state_next = ST_WAIT;
                            end
                        end
                        REQ_DUMP_FWD, REQ_DUMP_REV:
                        begin
                            if (stat.empty)
                            begin
                                cmd.op         = OP_ERROR;
                                cmd.err_status = STAT_EMPTY;
                            end
                            else
                            begin
                                cmd.op      = OP_DUMP_READ;
                                cmd.reverse = (req_type == REQ_DUMP_REV);
                                cmd.walk    = '0;
                                cmd.last    = (stat.count == CNT_W'(1));
                                rev_next    = (req_type == REQ_DUMP_REV);
                                walk_next   = IDX_W'(1);
                                state_next  = cmd.last ? ST_WAIT : ST_DUMP;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_DUMP:
            begin
                cmd.op    = OP_DUMP_READ;
                cmd.last  = walk_last;
                walk_next = walk_reg + IDX_W'(1);
                if (walk_last)
                    state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            walk_reg  <= '0;
            rev_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            walk_reg  <= walk_next;
            rev_reg   <= rev_next;
        end
    end

    // Checks
    a_wait_one: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WAIT) |=> (state_reg == ST_IDLE))
        else $error("wait state held longer than one cycle");

    a_state_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) || (state_reg == ST_DUMP) || (state_reg == ST_WAIT))
        else $error("controller in an unknown state");

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DUMP) |-> (CNT_W'(walk_reg) < stat.count))
        else $error("dump walk past the last entry");

endmodule

`default_nettype wire

[design/double_ended_queue.sv]
// Top level of the double-ended queue: controller plus datapath.
//
// Bounded deque of 64 signed 32-bit entries. An item is taken when start is
// high and busy is low. Each result is shown for one cycle with result_valid
// high; the receiver cannot hold results off. Timing: the result of a push,
// or of any request that is flagged (full on push, empty on pop or dump),
// appears in the cycle after it is taken. A pop result passes through the
// registered read of the ring store and then the result registers. A dump of
// n entries does one store read per cycle and emits its n results on
// consecutive cycles, the last marked by last_of_run. Request codes six and
// seven are taken and ignored. The store needs no clearing after reset.
`default_nettype none

module double_ended_queue (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [2:0]                        req_type,
    input  wire logic signed [deq_pkg::DATA_W-1:0] push_value,
    output logic                                   result_valid,
    output logic signed [deq_pkg::DATA_W-1:0]      out_value,
    output logic [1:0]                             status,
    output logic                                   queue_empty,
    output logic                                   last_of_run
);
    import deq_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t dp_stat;

    deq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .stat     (dp_stat),
        .busy     (busy),
        .cmd      (cmd)
    );

    deq_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .push_value   (push_value),
        .stat         (dp_stat),
        .result_valid (result_valid),
        .out_value    (out_value),
        .status       (status),
        .queue_empty  (queue_empty),
        .last_of_run  (last_of_run)
    );

endmodule

`default_nettype wire

[bench/tb_double_ended_queue.sv]
// Self-checking testbench for the double-ended queue: directed and random requests.
module tb_double_ended_queue;
    timeunit 1ns;
    timeprecision 1ps;

    import deq_pkg::*;

    // Request codes the block takes and ignores
    localparam logic [2:0] REQ_UNUSED_6 = 3'd6;
    localparam logic [2:0] REQ_UNUSED_7 = 3'd7;

    // Longest dump gives DEPTH results
    localparam int DRAIN_CYCLES = DEPTH + 8;
    localparam int STALL_LIMIT  = 2000;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [1:0]               status;
        logic                     empty;
        logic                     last;
    } deq_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [2:0]               req_type = REQ_PUSH_BACK;
    logic signed [DATA_W-1:0] push_value = '0;
    logic                     result_valid;
    logic signed [DATA_W-1:0] out_value;
    logic [1:0]               status;
    logic                     queue_empty;
    logic                     last_of_run;

    // Shadow copy of the queue
    logic signed [DATA_W-1:0] shadow_ring [DEPTH];
    int                       shadow_head = 0;
    int                       shadow_count = 0;

    deq_result_t              pending_results [$];
    int                       fail_count = 0;
    int                       sender_idle_pct = 0;
    int                       idle_cycles = 0;

    double_ended_queue DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .push_value   (push_value),
        .result_valid (result_valid),
        .out_value    (out_value),
        .status       (status),
        .queue_empty  (queue_empty),
        .last_of_run  (last_of_run)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Queue one expected result; empty flag reflects the shadow after the request
    function automatic void add_expected(input logic signed [DATA_W-1:0] value,
                                         input logic [1:0] stat, input logic last);
        deq_result_t r;
        r.value  = value;
        r.status = stat;
        r.empty  = (shadow_count == 0);
        r.last   = last;
        pending_results.push_back(r);
    endfunction

    // Apply one accepted request to the shadow and record its results
    function automatic void predict_request(input logic [2:0] req,
                                            input logic signed [DATA_W-1:0] val);
        int pos;
        case (req)
            REQ_PUSH_BACK, REQ_PUSH_FRONT:
            begin
                if (shadow_count >= DEPTH)
                    add_expected('0, STAT_FULL, 1'b1);
                else
                begin
                    if (req == REQ_PUSH_BACK)
                        shadow_ring[(shadow_head + shadow_count) % DEPTH] = val;
                    else
                    begin
                        shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
                        shadow_ring[shadow_head] = val;
                    end
                    shadow_count++;
                    add_expected('0, STAT_OK, 1'b1);
                end
            end
            REQ_POP_BACK, REQ_POP_FRONT:
            begin
                if (shadow_count == 0)
                    add_expected('0, STAT_EMPTY, 1'b1);
                else
                begin
                    if (req == REQ_POP_BACK)
                        pos = (shadow_head + shadow_count - 1) % DEPTH;
                    else
                    begin
                        // head stays put when the last entry leaves from the back only
                        pos = shadow_head;
                        shadow_head = (shadow_head + 1) % DEPTH;
                    end
                    shadow_count--;
                    add_expected(shadow_ring[pos], STAT_OK, 1'b1);
                end
            end
            REQ_DUMP_FWD, REQ_DUMP_REV:
            begin
                if (shadow_count == 0)
                    add_expected('0, STAT_EMPTY, 1'b1);
                else
                    for (int k = 0; k < shadow_count; k++)
                    begin
                        pos = (req == REQ_DUMP_FWD) ? k : shadow_count - 1 - k;
                        add_expected(shadow_ring[(shadow_head + pos) % DEPTH], STAT_OK,
                                     k == shadow_count - 1);
                    end
            end
            default:
            begin
                // unused codes: no state change, no result
            end
        endcase
    endfunction

    // Send one item; called and returns at a falling edge
    task automatic send_request(input logic [2:0] req, input logic signed [DATA_W-1:0] val);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start      <= 1'b1;
        req_type   <= req;
        push_value <= val;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_request(req, val);
        @(negedge clk);
    endtask

    // Hold off until every expected result has come back
    task automatic wait_for_drain();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(11))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Pops and dumps on an empty queue are flagged
    task automatic test_empty_requests();
        send_request(REQ_POP_BACK, 32'sd5);
        send_request(REQ_POP_FRONT, -32'sd5);
        send_request(REQ_DUMP_FWD, '0);
        send_request(REQ_DUMP_REV, -32'sd1);
    endtask

    // Codes six and seven are swallowed
    task automatic test_unused_codes();
        send_request(REQ_UNUSED_6, 32'sh5555_5555);
        send_request(REQ_UNUSED_7, 32'shaaaa_aaaa);
    endtask

    // Extreme values at both ends, head wraps below zero and back
    task automatic test_ends_and_wrap();
        send_request(REQ_PUSH_BACK, 32'sh7fff_ffff);
        send_request(REQ_PUSH_FRONT, 32'sh8000_0000);
        send_request(REQ_PUSH_BACK, -32'sd1);
        send_request(REQ_PUSH_FRONT, '0);
        send_request(REQ_DUMP_FWD, '0);
        send_request(REQ_DUMP_REV, '0);
        send_request(REQ_POP_FRONT, '0);
        send_request(REQ_POP_BACK, '0);
        send_request(REQ_POP_FRONT, '0);
        send_request(REQ_POP_BACK, '0);
        // single entry leaves from the front
        send_request(REQ_PUSH_FRONT, 32'sd1);
        send_request(REQ_POP_FRONT, '0);
    endtask

    // Fill to capacity, overflow, dump, then drain past empty
    task automatic test_fill_to_full();
        while (shadow_count < DEPTH)
            send_request($urandom_range(1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK, pick_value());
        send_request(REQ_PUSH_BACK, pick_value());
        send_request(REQ_PUSH_FRONT, pick_value());
        send_request(REQ_DUMP_FWD, '0);
        send_request(REQ_DUMP_REV, '0);
        while (shadow_count > 0)
            send_request($urandom_range(1) ? REQ_POP_FRONT : REQ_POP_BACK, pick_value());
        send_request(REQ_POP_FRONT, '0);
    endtask

    // Random mix leaning toward pushes so the queue grows and wraps
    task automatic test_random_mix(input int num_items);
        int          pick;
        logic [2:0]  req;
        for (int n = 0; n < num_items; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 23)
                req = REQ_PUSH_BACK;
            else if (pick < 46)
                req = REQ_PUSH_FRONT;
            else if (pick < 63)
                req = REQ_POP_BACK;
            else if (pick < 80)
                req = REQ_POP_FRONT;
            else if (pick < 86)
                req = REQ_DUMP_FWD;
            else if (pick < 92)
                req = REQ_DUMP_REV;
            else
                req = $urandom_range(1) ? REQ_UNUSED_6 : REQ_UNUSED_7;
            send_request(req, pick_value());
        end
    endtask

    // Compare each result with the oldest expectation
    always @(posedge clk)
    begin : check_results
        deq_result_t want;
        if (rst_n && result_valid)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: out_value %0d status %0d", out_value, status);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_value !== want.value)
                begin
                    $error("out_value: expected %0d, got %0d", want.value, out_value);
                    fail_count++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    fail_count++;
                end
                if (queue_empty !== want.empty)
                begin
                    $error("queue_empty: expected %0b, got %0b", want.empty, queue_empty);
                    fail_count++;
                end
                if (last_of_run !== want.last)
                begin
                    $error("last_of_run: expected %0b, got %0b", want.last, last_of_run);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: ends the run when neither side moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("double_ended_queue test failed");
            $finish;
        end
    end

    // Test sequence
    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        sender_idle_pct = 37;
        test_empty_requests();
        test_unused_codes();
        test_ends_and_wrap();
        test_fill_to_full();
        test_random_mix(60);
        wait_for_drain();

        sender_idle_pct = 88;
        test_random_mix(120);

        sender_idle_pct = 0;
        test_random_mix(140);

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("double_ended_queue test passed");
        else
            $display("double_ended_queue test failed");
        $finish;
    end

endmodule
